// ===== hw/rtl/ttc_pkg.sv =====
package ttc_pkg;

    // Block geometry
    localparam int TILE_SIZE  = 16;
    localparam int LANES      = (TILE_SIZE < 16) ? TILE_SIZE : 16;
    localparam int COORD_W    = 20;
    localparam int TILE_IDX_W = 9;
    localparam int ROW_W      = 4;
    localparam int MASK_W     = 16;
    localparam int CLASS_W    = 2;

    // Configuration registers
    localparam int SR_W      = 3;
    localparam int TW_W      = 12;
    localparam int TH_W      = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W     = TW_W + SR_W;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd2;

    localparam logic [SR_W-1:0] SR_RESET = 3'd1;
    localparam logic [TW_W-1:0] TW_RESET = 12'd640;
    localparam logic [TH_W-1:0] TH_RESET = 12'd480;

    // Stream widths
    localparam int S_TDATA_W = ((6 * COORD_W + 2 * TILE_IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ROW_W + MASK_W + 7) / 8) * 8;

    // Datapath widths
    localparam int POS_W = $clog2((1 << TILE_IDX_W) * TILE_SIZE + TILE_SIZE + 1);
    localparam int VW    = COORD_W + SR_W + 1;
    localparam int AW    = VW + 1;
    localparam int PW    = 2 * VW;
    localparam int DW    = 2 * AW;
    localparam int HW    = POS_W + 2;
    localparam int XW    = AW + HW;
    localparam int EW    = ((PW + 1 > XW + 4) ? PW + 1 : XW + 4) + 2;
    localparam int CMP_W = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;

    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [EW-1:0] edge_t;

    // Edge value change from one tile corner to the next, 8 fractional bits
    localparam edge_t CORNER_K = edge_t'(16 * TILE_SIZE);

    typedef enum logic [CLASS_W-1:0] {
        CLASS_REJECT  = 2'd0,
        CLASS_PARTIAL = 2'd1,
        CLASS_FULL    = 2'd2
    } tile_class_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] vx;
        logic [2:0][COORD_W-1:0] vy;
        logic [TILE_IDX_W-1:0]   tile_col;
        logic [TILE_IDX_W-1:0]   tile_row;
    } tri_item_t;

    typedef struct packed {
        tile_class_t      tile_class;
        edge_t [2:0]      e0;
        edge_t [2:0]      step_x;
        edge_t [2:0]      step_y;
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] y0;
    } tile_setup_t;

    function automatic int next_edge(int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

endpackage

// ===== hw/rtl/ttc_front.sv =====
module ttc_front import ttc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tri_item_t         in_item,
    input  logic [SR_W-1:0]   sample_scale,
    output logic              q_valid,
    input  logic              q_ready,
    output tile_setup_t       q_data
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic              advance;

    // Stage 1: scaled vertices and tile origin
    logic signed [VW-1:0] vx_reg [3];
    logic signed [VW-1:0] vy_reg [3];
    logic [POS_W-1:0]     x0_reg [5];
    logic [POS_W-1:0]     y0_reg [5];

    // Stage 2: edge coefficients and the cross products of c
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] b_reg [3];
    logic signed [PW-1:0] pc1_reg [3];
    logic signed [PW-1:0] pc2_reg [3];

    // Stage 3: c, determinant products, corner products
    edge_t                c3_reg [3];
    logic signed [AW-1:0] a3_reg [3];
    logic signed [AW-1:0] b3_reg [3];
    logic signed [DW-1:0] pd1_reg;
    logic signed [DW-1:0] pd2_reg;
    logic signed [XW-1:0] pax_reg [3];
    logic signed [XW-1:0] pby_reg [3];

    // Stage 4: determinant sign and edge value at the tile origin
    edge_t a4_reg [3];
    edge_t b4_reg [3];
    edge_t base4_reg [3];
    logic  dneg_reg;
    logic  dzero4_reg;

    // Stage 5: orientation applied
    edge_t a5_reg [3];
    edge_t b5_reg [3];
    edge_t base5_reg [3];
    logic  dzero5_reg;

    // Stage 6: classified setup
    tile_setup_t setup_reg;
    tile_setup_t setup_next;

    logic signed [HW-1:0] hx;
    logic signed [HW-1:0] hy;
    logic signed [DW:0]   det;

    assign advance  = !vld_reg[STAGES-1] || q_ready;
    assign in_ready = advance;
    assign q_valid  = vld_reg[STAGES-1];
    assign q_data   = setup_reg;

    assign hx  = {1'b0, x0_reg[1], 1'b0};
    assign hy  = {1'b0, y0_reg[1], 1'b0};
    assign det = (DW + 1)'(pd1_reg) - (DW + 1)'(pd2_reg);

    always_comb begin
        edge_t ka;
        edge_t kb;
        edge_t cor [4];
        logic  any_all;
        logic  any_neg;
        any_all = 1'b0;
        any_neg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ka = a5_reg[i] * CORNER_K;
            kb = b5_reg[i] * CORNER_K;
            cor[0] = base5_reg[i];
            cor[1] = base5_reg[i] + ka;
            cor[2] = base5_reg[i] + kb;
            cor[3] = base5_reg[i] + ka + kb;
            if (cor[0][EW-1] && cor[1][EW-1] && cor[2][EW-1] && cor[3][EW-1]) begin
                any_all = 1'b1;
            end
            if (cor[0][EW-1] || cor[1][EW-1] || cor[2][EW-1] || cor[3][EW-1]) begin
                any_neg = 1'b1;
            end
            // Center of the first sample sits half a sample in on both axes.
            setup_next.e0[i]     = base5_reg[i] + (a5_reg[i] <<< 3) + (b5_reg[i] <<< 3);
            setup_next.step_x[i] = a5_reg[i] <<< 4;
            setup_next.step_y[i] = b5_reg[i] <<< 4;
        end
        if (dzero5_reg || any_all) begin
            setup_next.tile_class = CLASS_REJECT;
        end else if (any_neg) begin
            setup_next.tile_class = CLASS_PARTIAL;
        end else begin
            setup_next.tile_class = CLASS_FULL;
        end
        setup_next.x0 = x0_reg[4];
        setup_next.y0 = y0_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                vx_reg[i] <= VW'($signed(in_item.vx[i])) * VW'($signed({1'b0, sample_scale}));
                vy_reg[i] <= VW'($signed(in_item.vy[i])) * VW'($signed({1'b0, sample_scale}));
            end
            x0_reg[0] <= POS_W'(in_item.tile_col * TILE_SIZE);
            y0_reg[0] <= POS_W'(in_item.tile_row * TILE_SIZE);
            for (int s = 1; s < 5; s++) begin
                x0_reg[s] <= x0_reg[s-1];
                y0_reg[s] <= y0_reg[s-1];
            end

            for (int i = 0; i < 3; i++) begin
                a_reg[i]   <= AW'(vy_reg[i]) - AW'(vy_reg[next_edge(i)]);
                b_reg[i]   <= AW'(vx_reg[next_edge(i)]) - AW'(vx_reg[i]);
                pc1_reg[i] <= PW'(vy_reg[next_edge(i)]) * PW'(vx_reg[i]);
                pc2_reg[i] <= PW'(vy_reg[i]) * PW'(vx_reg[next_edge(i)]);
            end

            for (int i = 0; i < 3; i++) begin
                c3_reg[i]  <= edge_t'(pc1_reg[i]) - edge_t'(pc2_reg[i]);
                a3_reg[i]  <= a_reg[i];
                b3_reg[i]  <= b_reg[i];
                pax_reg[i] <= XW'(a_reg[i]) * XW'(hx);
                pby_reg[i] <= XW'(b_reg[i]) * XW'(hy);
            end
            pd1_reg <= DW'(b_reg[0]) * DW'(a_reg[2]);
            pd2_reg <= DW'(b_reg[2]) * DW'(a_reg[0]);

            for (int i = 0; i < 3; i++) begin
                a4_reg[i]    <= edge_t'(a3_reg[i]);
                b4_reg[i]    <= edge_t'(b3_reg[i]);
                base4_reg[i] <= ((edge_t'(pax_reg[i]) + edge_t'(pby_reg[i])) <<< 3) + c3_reg[i];
            end
            dneg_reg   <= det[DW];
            dzero4_reg <= (det == '0);

            // A clockwise triangle has every edge function flipped.
            for (int i = 0; i < 3; i++) begin
                a5_reg[i]    <= dneg_reg ? -a4_reg[i] : a4_reg[i];
                b5_reg[i]    <= dneg_reg ? -b4_reg[i] : b4_reg[i];
                base5_reg[i] <= dneg_reg ? -base4_reg[i] : base4_reg[i];
            end
            dzero5_reg <= dzero4_reg;

            setup_reg <= setup_next;
        end
    end

endmodule

// ===== hw/rtl/ttc_queue.sv =====
module ttc_queue import ttc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  tile_setup_t push_data,
    output logic        pop_valid,
    input  logic        pop,
    output tile_setup_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tile_setup_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ttc_back.sv =====
module ttc_back import ttc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DIM_W-1:0]   width_lim,
    input  logic [DIM_W-1:0]   height_lim,
    input  logic               q_valid,
    output logic               q_pop,
    input  tile_setup_t        q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ROW_W-1:0]   out_row,
    output logic [MASK_W-1:0]  out_mask,
    output logic [CLASS_W-1:0] out_class,
    output logic               out_last
);

    logic             busy_reg;
    logic [ROW_W-1:0] row_reg;
    tile_class_t      cls_reg;
    edge_t            lane_reg [3][LANES];
    edge_t            stepy_reg [3];
    logic [LANES-1:0] xok_reg;
    logic [LANES-1:0] xok_next;
    logic [POS_W-1:0] y_reg;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic               out_last_reg;

    logic              out_free;
    logic              emit;
    logic              is_reject;
    logic              row_last;
    logic              y_ok;
    logic [MASK_W-1:0] mask_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign is_reject = (cls_reg == CLASS_REJECT);
    assign row_last  = is_reject || (row_reg == ROW_W'(LANES - 1));
    // The next setup loads in the same cycle as the final row leaves.
    assign q_pop     = q_valid && (!busy_reg || (emit && row_last));
    assign y_ok      = CMP_W'(y_reg) < CMP_W'(height_lim);

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_mask  = out_mask_reg;
    assign out_class = out_class_reg;
    assign out_last  = out_last_reg;

    always_comb begin
        mask_next = '0;
        for (int k = 0; k < LANES; k++) begin
            mask_next[k] = !is_reject && y_ok && xok_reg[k] &&
                           !lane_reg[0][k][EW-1] && !lane_reg[1][k][EW-1] &&
                           !lane_reg[2][k][EW-1];
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            xok_next[k] = (CMP_W'(q_data.x0) + CMP_W'(k)) < CMP_W'(width_lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= emit;
            end
            if (q_pop) begin
                busy_reg <= 1'b1;
            end else if (emit && row_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_row_reg   <= row_reg;
            out_mask_reg  <= mask_next;
            out_class_reg <= cls_reg;
            out_last_reg  <= row_last;
        end
        if (q_pop) begin
            row_reg <= '0;
            y_reg   <= q_data.y0;
            cls_reg <= q_data.tile_class;
            xok_reg <= xok_next;
            for (int i = 0; i < 3; i++) begin
                stepy_reg[i] <= $signed(q_data.step_y[i]);
                for (int k = 0; k < LANES; k++) begin
                    lane_reg[i][k] <= $signed(q_data.e0[i]) +
                                      $signed(q_data.step_x[i]) * edge_t'(k);
                end
            end
        end else if (emit) begin
            row_reg <= row_reg + 1'b1;
            y_reg   <= y_reg + 1'b1;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < LANES; k++) begin
                    lane_reg[i][k] <= lane_reg[i][k] + stepy_reg[i];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/triangle_tile_coverage.sv =====
// Tile coverage unit: tests one triangle against one tile of supersampled space.
// The slave channel takes one item per transfer: three vertices in signed
// fixed point with four fractional bits and a tile column and row. The master
// channel gives one transfer per sample row with the row number, a 16-bit
// coverage mask and the tile class on tuser; tlast marks the final row of the
// item. A rejected tile gives a single transfer with an empty mask.
// Configuration (sample rate, target width and height) is written through the
// plain write port; the user must write it only while no item is in flight,
// as the block itself does not enforce this. A six-stage setup pipeline takes
// an item every cycle unless stalled and feeds a two-entry queue; the row
// scanner emits one row per cycle while its output register is free. A partial
// or full tile occupies the row scanner for all 16 rows, a rejected tile for
// one row, and the setup pipeline keeps taking items while the queue has room.
// Reset empties the pipeline, queue and output register and restores the
// registers to sample rate 1 and a 640 by 480 target. When the receiver holds
// m_tready low, the output register keeps its transfer, the scanner and queue
// fill, and the setup pipeline then stalls and drops s_tready.
module triangle_tile_coverage import ttc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    // tile_col, tile_row, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_in_tile, coverage_mask, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // tile_class
    output logic [CLASS_W-1:0]   m_tuser,
    // last_row
    output logic                 m_tlast
);

    logic [SR_W-1:0]  sr_reg;
    logic [TW_W-1:0]  tw_reg;
    logic [TH_W-1:0]  th_reg;
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;

    tri_item_t   item;
    logic        fq_valid;
    logic        fq_ready;
    tile_setup_t fq_data;
    logic        qb_valid;
    logic        qb_pop;
    tile_setup_t qb_data;

    logic [ROW_W-1:0]  out_row;
    logic [MASK_W-1:0] out_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg <= SR_RESET;
            tw_reg <= TW_RESET;
            th_reg <= TH_RESET;
            w_reg  <= DIM_W'(TW_RESET * SR_RESET);
            h_reg  <= DIM_W'(TH_RESET * SR_RESET);
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_RATE:   sr_reg <= cfg_wdata[SR_W-1:0];
                    REG_TARGET_WIDTH:  tw_reg <= cfg_wdata[TW_W-1:0];
                    REG_TARGET_HEIGHT: th_reg <= cfg_wdata[TH_W-1:0];
                    default: ;
                endcase
            end
            w_reg <= {{SR_W{1'b0}}, tw_reg} * {{TW_W{1'b0}}, sr_reg};
            h_reg <= {{SR_W{1'b0}}, th_reg} * {{TH_W{1'b0}}, sr_reg};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            item.vx[i] = s_tdata[2 * i * COORD_W +: COORD_W];
            item.vy[i] = s_tdata[(2 * i + 1) * COORD_W +: COORD_W];
        end
        item.tile_col = s_tdata[6 * COORD_W +: TILE_IDX_W];
        item.tile_row = s_tdata[6 * COORD_W + TILE_IDX_W +: TILE_IDX_W];
    end

    ttc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (item),
        .sample_scale (sr_reg),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    ttc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop        (qb_pop),
        .pop_data   (qb_data)
    );

    ttc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .width_lim  (w_reg),
        .height_lim (h_reg),
        .q_valid    (qb_valid),
        .q_pop      (qb_pop),
        .q_data     (qb_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_row    (out_row),
        .out_mask   (out_mask),
        .out_class  (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - ROW_W - MASK_W){1'b0}}, out_mask, out_row};

endmodule
